// ----- design/tch_pkg.sv -----
// ----------------------------------------------------------------------------
// tch_pkg: shared types and constants for the tilt compensated heading block
// Register indexes, reset values, angle units and the CORDIC arctangent list.
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int NUM_REGS = 7;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ACCEL_ROW0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_ROW1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_ROW2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAG_ROW0   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAG_ROW1   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAG_ROW2   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FACING     = 3'd6;

  localparam logic [63:0] RESET_ROW0   = 64'h0000_4000_0000_0000;
  localparam logic [63:0] RESET_ROW1   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] RESET_ROW2   = 64'h0000_0000_0000_4000;
  localparam logic [63:0] RESET_FACING = 64'h4000_0000_0000_0000;

  localparam int DEG_FULL      = 360;
  localparam int UNITS_PER_DEG = 64;
  localparam int TURN_UNITS    = DEG_FULL * UNITS_PER_DEG;
  localparam int HEADING_W     = 15;

  localparam int MAX_STAGES = 24;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Width of one calibrated axis: sample minus bias, times Q2.14, sum of three.
  function automatic int calib_width(input int sw);
    return ((sw > 16) ? sw : 16) + 1 + 16 + 2;
  endfunction

  // atan(2^-i) as a 32-bit binary angle.
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/tch_fifo.sv -----
// ----------------------------------------------------------------------------
// tch_fifo: small synchronous queue
// Register-array queue with occupancy count; full and empty come from the count.
// ----------------------------------------------------------------------------
module tch_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- design/tch_norm.sv -----
// ----------------------------------------------------------------------------
// tch_norm: vector rescale unit
// Shifts all components by one amount so the largest magnitude gets TARGET
// bits. Three stages: magnitudes, leading-one search, shift.
// ----------------------------------------------------------------------------
module tch_norm #(
  parameter int W      = 33,
  parameter int N      = 3,
  parameter int TARGET = 15,
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [N*W-1:0]            in_vec,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [N*(TARGET+1)-1:0]   out_vec,
  output logic                      out_zero,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int OW  = TARGET + 1;
  localparam int MW  = (W > TARGET) ? W : TARGET;
  localparam int SHW = $clog2(MW + 1);

  // stage 1
  logic              v1;
  logic [W-1:0]      mag1 [N];
  logic [N-1:0]      neg1;
  logic [W-1:0]      orv1;
  logic [SIDE_W-1:0] side1;
  // stage 2
  logic              v2;
  logic [W-1:0]      mag2 [N];
  logic [N-1:0]      neg2;
  logic [SHW-1:0]    len2;
  logic              zero2;
  logic [SIDE_W-1:0] side2;

  logic [W-1:0]   mag_c [N];
  logic [W-1:0]   orv_c;
  logic [SHW-1:0] len_c;

  always_comb begin
    orv_c = '0;
    for (int i = 0; i < N; i++) begin
      mag_c[i] = in_vec[i*W+W-1] ? (~in_vec[i*W +: W] + 1'b1) : in_vec[i*W +: W];
      orv_c    = orv_c | mag_c[i];
    end
  end

  always_comb begin
    len_c = '0;
    for (int b = 0; b < W; b++) begin
      if (orv1[b]) begin
        len_c = SHW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        mag1[i] <= mag_c[i];
        neg1[i] <= in_vec[i*W+W-1];
        mag2[i] <= mag1[i];
      end
      orv1  <= orv_c;
      side1 <= in_side;
      neg2  <= neg1;
      len2  <= len_c;
      zero2 <= (orv1 == '0);
      side2 <= side1;
    end
  end

  // stage 3: one shift for every component
  logic [MW-1:0] sh_c [N];
  logic [OW-1:0] res_c [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (len2 > SHW'(TARGET)) begin
        sh_c[i] = MW'(mag2[i]) >> (len2 - SHW'(TARGET));
      end else begin
        sh_c[i] = MW'(mag2[i]) << (SHW'(TARGET) - len2);
      end
      res_c[i] = neg2[i] ? (~{1'b0, sh_c[i][TARGET-1:0]} + 1'b1)
                         : {1'b0, sh_c[i][TARGET-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        out_vec[i*OW +: OW] <= res_c[i];
      end
      out_zero <= zero2;
      out_side <= side2;
    end
  end

endmodule

// ----- design/tch_front.sv -----
// ----------------------------------------------------------------------------
// tch_front: sensor calibration front end
// Subtracts the biases and applies both 3x3 calibration matrices in three
// pipeline stages: difference, products, row sums.
// ----------------------------------------------------------------------------
module tch_front #(
  parameter int SW = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [5:0][SW-1:0]                  raw,
  input  logic [5:0][63:0]                    rows,
  output logic                                out_valid,
  output logic [6*tch_pkg::calib_width(SW)-1:0] out_vec
);

  localparam int DW = ((SW > 16) ? SW : 16) + 1;
  localparam int PW = DW + 16;
  localparam int CW = tch_pkg::calib_width(SW);

  logic                 v1;
  logic                 v2;
  logic signed [DW-1:0] d1 [6];
  logic signed [PW-1:0] p2 [6][3];
  logic signed [PW-1:0] p_c [6][3];
  logic signed [15:0]   cf  [6][3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      for (int c = 0; c < 3; c++) begin
        cf[k][c]  = $signed(rows[k][47-16*c -: 16]);
        p_c[k][c] = cf[k][c] * d1[(k/3)*3 + c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        d1[k] <= DW'($signed(raw[k])) - DW'($signed(rows[k][63:48]));
        for (int c = 0; c < 3; c++) begin
          p2[k][c] <= p_c[k][c];
        end
        out_vec[k*CW +: CW] <= CW'(p2[k][0]) + CW'(p2[k][1]) + CW'(p2[k][2]);
      end
    end
  end

endmodule

// ----- design/tch_cordic.sv -----
// ----------------------------------------------------------------------------
// tch_cordic: pipelined CORDIC arctangent
// Vectoring mode, one registered stage per iteration, plus a half-turn
// pre-rotation for vectors in the left half plane.
// ----------------------------------------------------------------------------
module tch_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [30:0] in_y,
  input  logic signed [30:0] in_x,
  input  logic               in_zero,
  input  logic               in_deg,
  output logic               out_valid,
  output logic [31:0]        out_angle,
  output logic               out_zero,
  output logic               out_deg
);

  localparam int XW = 34;

  logic signed [XW-1:0] sx [STAGES+1];
  logic signed [XW-1:0] sy [STAGES+1];
  logic [31:0]          sz [STAGES+1];
  logic                 sv [STAGES+1];
  logic                 szero [STAGES+1];
  logic                 sdeg [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_x < 0) begin
        sx[0] <= -XW'(in_x);
        sy[0] <= -XW'(in_y);
        sz[0] <= tch_pkg::HALF_TURN;
      end else begin
        sx[0] <= XW'(in_x);
        sy[0] <= XW'(in_y);
        sz[0] <= '0;
      end
      szero[0] <= in_zero;
      sdeg[0]  <= in_deg;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = sx[i] >>> i;
    assign dy = sy[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sy[i] > 0) begin
          sx[i+1] <= sx[i] + dy;
          sy[i+1] <= sy[i] - dx;
          sz[i+1] <= sz[i] + tch_pkg::atan_turn(i);
        end else begin
          sx[i+1] <= sx[i] - dy;
          sy[i+1] <= sy[i] + dx;
          sz[i+1] <= sz[i] - tch_pkg::atan_turn(i);
        end
        szero[i+1] <= szero[i];
        sdeg[i+1]  <= sdeg[i];
      end
    end
  end

  assign out_valid = sv[STAGES];
  assign out_angle = sz[STAGES];
  assign out_zero  = szero[STAGES];
  assign out_deg   = sdeg[STAGES];

endmodule

// ----- design/tch_back.sv -----
// ----------------------------------------------------------------------------
// tch_back: heading back end
// Rescales both sensor vectors, forms west and north, projects them onto the
// facing vector, takes the CORDIC angle and converts it to a wrapped heading.
// ----------------------------------------------------------------------------
module tch_back #(
  parameter int CW     = 35,
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [6*CW-1:0]                     in_vec,
  input  logic [63:0]                         facing_decl,
  output logic                                out_valid,
  output logic [tch_pkg::HEADING_W-1:0]       out_heading,
  output logic                                out_degenerate
);

  localparam int XW = 33;
  localparam int DTW = 34;
  localparam int HW = tch_pkg::HEADING_W;
  localparam int T1 = tch_pkg::TURN_UNITS;

  function automatic logic signed [XW-1:0] xterm(
    input logic signed [15:0] a, input logic signed [15:0] b,
    input logic signed [15:0] c, input logic signed [15:0] d);
    logic signed [XW-1:0] p;
    logic signed [XW-1:0] q;
    p = a * b;
    q = c * d;
    return p - q;
  endfunction

  function automatic logic [3*XW-1:0] cross3(input logic [47:0] u, input logic [47:0] v);
    logic signed [15:0] a0, a1, a2, b0, b1, b2;
    a0 = u[15:0];  a1 = u[31:16]; a2 = u[47:32];
    b0 = v[15:0];  b1 = v[31:16]; b2 = v[47:32];
    return {xterm(a0, b1, a1, b0), xterm(a2, b0, a0, b2), xterm(a1, b2, a2, b1)};
  endfunction

  function automatic logic signed [DTW-1:0] dot3(input logic [47:0] u, input logic [63:0] f);
    logic signed [DTW-1:0] p0, p1, p2;
    p0 = $signed(u[15:0])  * $signed(f[63:48]);
    p1 = $signed(u[31:16]) * $signed(f[47:32]);
    p2 = $signed(u[47:32]) * $signed(f[31:16]);
    return p0 + p1 + p2;
  endfunction

  // rescale accelerometer
  logic              n1_valid, n1_zero;
  logic [47:0]       n1_vec;
  logic [3*CW-1:0]   n1_side;

  tch_norm #(.W(CW), .N(3), .TARGET(15), .SIDE_W(3*CW)) u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .in_vec(in_vec[3*CW-1:0]), .in_side(in_vec[6*CW-1:3*CW]),
    .out_valid(n1_valid), .out_vec(n1_vec), .out_zero(n1_zero), .out_side(n1_side)
  );

  // rescale magnetometer
  logic        n2_valid, n2_zero;
  logic [47:0] n2_vec;
  logic [48:0] n2_side;

  tch_norm #(.W(CW), .N(3), .TARGET(15), .SIDE_W(49)) u_norm_mag (
    .clk(clk), .rst(rst), .en(en), .in_valid(n1_valid),
    .in_vec(n1_side), .in_side({n1_vec, n1_zero}),
    .out_valid(n2_valid), .out_vec(n2_vec), .out_zero(n2_zero), .out_side(n2_side)
  );

  // flip magnetometer y and z, then west = up x mag
  logic [47:0]   mg_c;
  logic          x1_valid, x1_deg;
  logic [3*XW-1:0] x1_west;
  logic [47:0]   x1_up;

  assign mg_c = {16'(-$signed(n2_vec[47:32])), 16'(-$signed(n2_vec[31:16])), n2_vec[15:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_valid <= 1'b0;
    end else if (en) begin
      x1_valid <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_west <= cross3(n2_side[48:1], mg_c);
      x1_up   <= n2_side[48:1];
      x1_deg  <= n2_side[0] | n2_zero;
    end
  end

  logic        n3_valid, n3_zero;
  logic [47:0] n3_vec;
  logic [48:0] n3_side;

  tch_norm #(.W(XW), .N(3), .TARGET(15), .SIDE_W(49)) u_norm_west (
    .clk(clk), .rst(rst), .en(en), .in_valid(x1_valid),
    .in_vec(x1_west), .in_side({x1_up, x1_deg}),
    .out_valid(n3_valid), .out_vec(n3_vec), .out_zero(n3_zero), .out_side(n3_side)
  );

  // north = west x up
  logic            x2_valid, x2_deg;
  logic [3*XW-1:0] x2_north;
  logic [47:0]     x2_west;

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_valid <= 1'b0;
    end else if (en) begin
      x2_valid <= n3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_north <= cross3(n3_vec, n3_side[48:1]);
      x2_west  <= n3_vec;
      x2_deg   <= n3_side[0] | n3_zero;
    end
  end

  logic        n4_valid, n4_zero;
  logic [47:0] n4_vec;
  logic [48:0] n4_side;

  tch_norm #(.W(XW), .N(3), .TARGET(15), .SIDE_W(49)) u_norm_north (
    .clk(clk), .rst(rst), .en(en), .in_valid(x2_valid),
    .in_vec(x2_north), .in_side({x2_west, x2_deg}),
    .out_valid(n4_valid), .out_vec(n4_vec), .out_zero(n4_zero), .out_side(n4_side)
  );

  // project onto the facing vector
  logic                  d_valid, d_deg;
  logic signed [DTW-1:0] d_y, d_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= n4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_y   <= dot3(n4_side[48:1], facing_decl);
      d_x   <= dot3(n4_vec, facing_decl);
      d_deg <= n4_side[0] | n4_zero;
    end
  end

  logic        n5_valid, n5_zero, n5_deg;
  logic [61:0] n5_vec;

  tch_norm #(.W(DTW), .N(2), .TARGET(30), .SIDE_W(1)) u_norm_dot (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid),
    .in_vec({d_x, d_y}), .in_side(d_deg),
    .out_valid(n5_valid), .out_vec(n5_vec), .out_zero(n5_zero), .out_side(n5_deg)
  );

  logic        c_valid, c_zero, c_deg;
  logic [31:0] c_angle;

  tch_cordic #(.STAGES(STAGES)) u_cordic (
    .clk(clk), .rst(rst), .en(en), .in_valid(n5_valid),
    .in_y($signed(n5_vec[30:0])), .in_x($signed(n5_vec[61:31])),
    .in_zero(n5_zero), .in_deg(n5_deg),
    .out_valid(c_valid), .out_angle(c_angle), .out_zero(c_zero), .out_deg(c_deg)
  );

  // turn fraction to 1/64 degree, rounded
  localparam logic [46:0] ROUND_HALF = 47'h0_8000_0000;
  logic [31:0]   t_c;
  logic [46:0]   prod_c;
  logic          m_valid, m_deg;
  logic [HW-1:0] m_units;

  assign t_c    = c_zero ? 32'd0 : (32'd0 - c_angle);
  assign prod_c = 47'(t_c) * 47'(T1) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_units <= prod_c[46:32];
      m_deg   <= c_deg;
    end
  end

  // add declination and wrap into one turn
  localparam logic signed [17:0] BIAS2 = 18'(2 * T1);
  localparam logic signed [17:0] TURN1 = 18'(T1);
  localparam logic signed [17:0] TURN2 = 18'(2 * T1);
  localparam logic signed [17:0] TURN3 = 18'(3 * T1);
  localparam logic signed [17:0] TURN4 = 18'(4 * T1);

  logic signed [17:0] s_c;
  logic signed [17:0] w_c;

  always_comb begin
    s_c = $signed({3'b000, m_units}) + 18'($signed(facing_decl[15:0])) + BIAS2;
    if (s_c >= TURN4) begin
      w_c = s_c - TURN4;
    end else if (s_c >= TURN3) begin
      w_c = s_c - TURN3;
    end else if (s_c >= TURN2) begin
      w_c = s_c - TURN2;
    end else if (s_c >= TURN1) begin
      w_c = s_c - TURN1;
    end else begin
      w_c = s_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_heading    <= m_deg ? '0 : w_c[HW-1:0];
      out_degenerate <= m_deg;
    end
  end

endmodule

// ----- design/tilt_compensated_heading.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_heading: tilt compensated compass heading
// Calibrates an accelerometer and magnetometer sample and returns the heading.
// ----------------------------------------------------------------------------
// Push one accelerometer and one magnetometer sample per beat; pop one heading
// per beat, in 1/64 degree, 0 at north and rising toward east, 0..23039. The
// block takes a new beat every cycle while full is low: the calibration front
// end feeds a four-entry queue, and the back end (vector rescaling, cross and
// dot products, the CORDIC and the degree conversion) drains it into a
// four-entry result queue, so a waiting result never stops input until both
// queues fill. The delay through the block comes from the rescale units (five
// of them in series) and the one-stage-per-iteration CORDIC. When the
// calibrated accelerometer, the calibrated magnetometer, west or north is a
// zero vector the result carries degenerate high and heading 0. If the
// facing vector is vertical or zero the heading is just the wrapped
// declination. Write configuration only while the block is idle; register
// indexes past the facing register are dropped. CORDIC_STAGES above 24 runs
// 24 stages.
// ----------------------------------------------------------------------------
module tilt_compensated_heading #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [tch_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data,
  // sample beats
  input  logic                              push,
  output logic                              full,
  input  logic [SAMPLE_WIDTH-1:0]           accel_x,
  input  logic [SAMPLE_WIDTH-1:0]           accel_y,
  input  logic [SAMPLE_WIDTH-1:0]           accel_z,
  input  logic [SAMPLE_WIDTH-1:0]           mag_x,
  input  logic [SAMPLE_WIDTH-1:0]           mag_y,
  input  logic [SAMPLE_WIDTH-1:0]           mag_z,
  // result beats
  output logic                              empty,
  input  logic                              pop,
  output logic [tch_pkg::HEADING_W-1:0]     heading,
  output logic                              degenerate
);

  localparam int CW = tch_pkg::calib_width(SAMPLE_WIDTH);
  localparam int STAGES = (CORDIC_STAGES > tch_pkg::MAX_STAGES) ?
                          tch_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int QDEPTH = 4;
  localparam int OUT_W = tch_pkg::HEADING_W + 1;

  // Configuration registers; the user must keep them static while items are in flight (not enforced here).
  logic [63:0] accel_row0, accel_row1, accel_row2;
  logic [63:0] mag_row0, mag_row1, mag_row2;
  logic [63:0] facing_decl;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_row0  <= tch_pkg::RESET_ROW0;
      accel_row1  <= tch_pkg::RESET_ROW1;
      accel_row2  <= tch_pkg::RESET_ROW2;
      mag_row0    <= tch_pkg::RESET_ROW0;
      mag_row1    <= tch_pkg::RESET_ROW1;
      mag_row2    <= tch_pkg::RESET_ROW2;
      facing_decl <= tch_pkg::RESET_FACING;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tch_pkg::REG_ACCEL_ROW0: accel_row0  <= cfg_data;
        tch_pkg::REG_ACCEL_ROW1: accel_row1  <= cfg_data;
        tch_pkg::REG_ACCEL_ROW2: accel_row2  <= cfg_data;
        tch_pkg::REG_MAG_ROW0:   mag_row0    <= cfg_data;
        tch_pkg::REG_MAG_ROW1:   mag_row1    <= cfg_data;
        tch_pkg::REG_MAG_ROW2:   mag_row2    <= cfg_data;
        tch_pkg::REG_FACING:     facing_decl <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: advance whenever the middle queue has room.
  logic            mid_full, mid_empty, mid_pop;
  logic            front_en, front_valid, in_accept;
  logic [6*CW-1:0] front_vec, mid_vec;

  assign front_en  = ~mid_full;
  assign full      = mid_full;
  assign in_accept = push & ~mid_full;

  tch_front #(.SW(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .en(front_en), .in_valid(in_accept),
    .raw({mag_z, mag_y, mag_x, accel_z, accel_y, accel_x}),
    .rows({mag_row2, mag_row1, mag_row0, accel_row2, accel_row1, accel_row0}),
    .out_valid(front_valid), .out_vec(front_vec)
  );

  tch_fifo #(.W(6*CW), .DEPTH(QDEPTH)) u_mid_q (
    .clk(clk), .rst(rst),
    .push(front_en & front_valid), .din(front_vec), .full(mid_full),
    .pop(mid_pop), .dout(mid_vec), .empty(mid_empty)
  );

  // Back end: hold the whole pipe when the result queue is full.
  logic                         out_full, back_en, back_valid, back_deg;
  logic [tch_pkg::HEADING_W-1:0] back_heading;

  assign back_en = ~out_full;
  assign mid_pop = back_en & ~mid_empty;

  tch_back #(.CW(CW), .STAGES(STAGES)) u_back (
    .clk(clk), .rst(rst), .en(back_en), .in_valid(mid_pop), .in_vec(mid_vec),
    .facing_decl(facing_decl),
    .out_valid(back_valid), .out_heading(back_heading), .out_degenerate(back_deg)
  );

  tch_fifo #(.W(OUT_W), .DEPTH(QDEPTH)) u_out_q (
    .clk(clk), .rst(rst),
    .push(back_en & back_valid), .din({back_deg, back_heading}), .full(out_full),
    .pop(pop), .dout({degenerate, heading}), .empty(empty)
  );

endmodule

// ----- design/tch_checker.sv -----
// ----------------------------------------------------------------------------
// tch_checker: port-level checks for the heading block
// Watches the result side of the top level and flags illegal results.
// ----------------------------------------------------------------------------
module tch_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic [tch_pkg::HEADING_W-1:0] heading,
  input logic                          degenerate
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (heading < tch_pkg::HEADING_W'(tch_pkg::TURN_UNITS)))
    else $error("heading outside one turn");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && degenerate) |-> (heading == '0))
    else $error("degenerate result with nonzero heading");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(heading) && $stable(degenerate)))
    else $error("waiting result changed or vanished");

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop),
  .heading(heading), .degenerate(degenerate)
);
